// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the keyed item table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define CKIT_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent
`define CKIT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ckit_pkg.sv =====
// ----------------------------------------------------------------------------
// ckit_pkg
// Types, codes and widths shared by the keyed item table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ckit_pkg;

  // Default table depth
  localparam int CAPACITY_DEF = 16;

  // Record layout, name key in the lowest bits
  localparam int KEY_BITS      = 256;
  localparam int TAG_BITS      = 192;
  localparam int AMT_BITS      = 32;
  localparam int REC_BITS      = KEY_BITS + TAG_BITS + AMT_BITS;
  localparam int SLOT_BITS     = 4;
  localparam int FUNC_BITS     = 2;
  localparam int STATUS_BITS   = 2;
  localparam int IN_PAD_BITS   = (8 - (REC_BITS % 8)) % 8;
  localparam int IN_DATA_BITS  = REC_BITS + IN_PAD_BITS;
  localparam int OUT_PAD_BITS  = (8 - ((REC_BITS + SLOT_BITS) % 8)) % 8;
  localparam int OUT_DATA_BITS = REC_BITS + SLOT_BITS + OUT_PAD_BITS;

  // Operation codes
  typedef enum logic [FUNC_BITS-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_LIST   = 2'd2,
    FN_SEARCH = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Source of the result word
  typedef enum logic [1:0] {
    OSRC_REQ    = 2'd0,
    OSRC_RD     = 2'd1,
    OSRC_STATUS = 2'd2
  } src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    req_load;
    logic    idx_inc;
    logic    ins_wr;
    logic    shift_wr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    src_t    out_src;
    status_t out_status;
    logic    out_last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    func_t func;
    logic  full;
    logic  empty;
    logic  match;
    logic  idx_last;
    logic  out_free;
  } sts_t;

endpackage

// ===== hdl/ckit_dpath.sv =====
// ----------------------------------------------------------------------------
// ckit_dpath
// Record memory, request and index registers, key compare and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ckit_dpath #(
  parameter int CAPACITY = ckit_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [ckit_pkg::IN_DATA_BITS-1:0]  in_tdata,
  input  logic [ckit_pkg::FUNC_BITS-1:0]     in_tuser,
  input  ckit_pkg::cmd_t                     cmd,
  output ckit_pkg::sts_t                     sts,
  output logic [$clog2(CAPACITY+1)-1:0]      entry_count,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ckit_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic [ckit_pkg::STATUS_BITS-1:0]   out_tuser,
  output logic                               out_tlast
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [ckit_pkg::REC_BITS-1:0]    mem_r [CAPACITY];
  logic [ckit_pkg::REC_BITS-1:0]    req_r;
  logic [ckit_pkg::REC_BITS-1:0]    rdata_r;
  ckit_pkg::func_t                  func_r;
  logic [IW-1:0]                    idx_r, idx_nxt;
  logic [CW-1:0]                    count_r, count_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [ckit_pkg::REC_BITS-1:0]    out_rec_r;
  logic [ckit_pkg::SLOT_BITS-1:0]   out_slot_r;
  ckit_pkg::status_t                out_status_r;
  logic                             out_last_r;
  logic                             wr_en;
  logic [IW-1:0]                    wr_addr;
  logic [ckit_pkg::REC_BITS-1:0]    wr_data;
  logic [ckit_pkg::REC_BITS-1:0]    res_rec;
  logic [ckit_pkg::SLOT_BITS-1:0]   res_slot;

  // Index and count update
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.req_load) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IW'(1);
    end
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Output word handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Memory write port: append at the count, or move an entry down one place
  assign wr_en   = cmd.ins_wr | cmd.shift_wr;
  assign wr_addr = cmd.ins_wr ? IW'(count_r) : (idx_r - IW'(1));
  assign wr_data = cmd.ins_wr ? req_r : rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rdata_r <= mem_r[idx_r];
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r  <= in_tdata[ckit_pkg::REC_BITS-1:0];
      func_r <= ckit_pkg::func_t'(in_tuser);
    end
  end

  // Result word select
  always_comb begin
    case (cmd.out_src)
      ckit_pkg::OSRC_REQ: begin
        res_rec  = req_r;
        res_slot = ckit_pkg::SLOT_BITS'(count_r);
      end
      ckit_pkg::OSRC_RD: begin
        res_rec  = rdata_r;
        res_slot = ckit_pkg::SLOT_BITS'(idx_r);
      end
      default: begin
        res_rec  = '0;
        res_slot = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rec_r    <= res_rec;
      out_slot_r   <= res_slot;
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
    end
  end

  // Status towards the controller
  always_comb begin
    sts.func     = func_r;
    sts.full     = (count_r == CW'(CAPACITY));
    sts.empty    = (count_r == '0);
    sts.match    = (rdata_r[ckit_pkg::KEY_BITS-1:0] == req_r[ckit_pkg::KEY_BITS-1:0]);
    sts.idx_last = ((CW'(idx_r) + CW'(1)) == count_r);
    sts.out_free = !out_valid_r || out_tready;
  end

  assign entry_count = count_r;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = {{ckit_pkg::OUT_PAD_BITS{1'b0}}, out_rec_r, out_slot_r};
  assign out_tuser   = out_status_r;
  assign out_tlast   = out_last_r;

endmodule

// ===== hdl/ckit_ctrl.sv =====
// ----------------------------------------------------------------------------
// ckit_ctrl
// Sequencer for insert, remove, list and search over the record memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ckit_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  ckit_pkg::sts_t sts,
  output ckit_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_INS,
    S_CHECK,
    S_STEP,
    S_SHRD,
    S_SHWR,
    S_STATUS
  } state_t;

  state_t            state_r, state_nxt;
  ckit_pkg::status_t code_r, code_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      // memory read of entry 0 is in flight here
      S_DISP: begin
        if (sts.func == ckit_pkg::FN_INSERT) begin
          if (sts.full) begin
            code_nxt  = ckit_pkg::ST_FULL;
            state_nxt = S_STATUS;
          end else begin
            state_nxt = S_INS;
          end
        end else if (sts.empty) begin
          code_nxt  = ckit_pkg::ST_EMPTY;
          state_nxt = S_STATUS;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_INS: begin
        if (sts.out_free) begin
          cmd.ins_wr     = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_src    = ckit_pkg::OSRC_REQ;
          cmd.out_status = ckit_pkg::ST_OK;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_CHECK: begin
        if (sts.func == ckit_pkg::FN_LIST) begin
          if (sts.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_src    = ckit_pkg::OSRC_RD;
            cmd.out_status = ckit_pkg::ST_OK;
            cmd.out_last   = sts.idx_last;
            if (sts.idx_last) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.idx_inc = 1'b1;
              state_nxt   = S_STEP;
            end
          end
        end else if (sts.match) begin
          if (sts.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_src    = ckit_pkg::OSRC_RD;
            cmd.out_status = ckit_pkg::ST_OK;
            cmd.out_last   = 1'b1;
            if (sts.func == ckit_pkg::FN_REMOVE) begin
              if (sts.idx_last) begin
                cmd.cnt_dec = 1'b1;
                state_nxt   = S_IDLE;
              end else begin
                cmd.idx_inc = 1'b1;
                state_nxt   = S_SHRD;
              end
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end else if (sts.idx_last) begin
          code_nxt  = ckit_pkg::ST_NOTFOUND;
          state_nxt = S_STATUS;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_STEP;
        end
      end
      // wait for the read of the new index
      S_STEP: begin
        state_nxt = S_CHECK;
      end
      S_SHRD: begin
        state_nxt = S_SHWR;
      end
      // entry at idx moves to idx-1
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        if (sts.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SHRD;
        end
      end
      S_STATUS: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_src    = ckit_pkg::OSRC_STATUS;
          cmd.out_status = code_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ckit_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

// ===== hdl/compacting_keyed_item_table.sv =====
// Sequence: a request is captured and decoded; insert appends the record, while search, remove
// and list scan the entries from slot 0, list giving one word per entry, and a miss ends in a
// status word. A registered read of one record per step drives the scan. Remove then moves each
// later entry down one place. One item at a time; the next is taken after the last word and any shift.
// Reset: synchronous active-low rst_n clears the entry count and the control state;
// record memory contents are left as they are and only read below the count.
// ----------------------------------------------------------------------------
// compacting_keyed_item_table
// Dense fixed-capacity record table with insert, remove by name, list and search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module compacting_keyed_item_table #(
  parameter int CAPACITY = ckit_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // key_word0, key_word1, key_word2, key_word3, tag_word0, tag_word1, tag_word2, amount_in
  input  logic [ckit_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // func
  input  logic [ckit_pkg::FUNC_BITS-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // slot, found_key0..3, found_tag0..2, found_amount, zero pad
  output logic [ckit_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // status
  output logic [ckit_pkg::STATUS_BITS-1:0]   out_tuser,
  output logic                               out_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);

  ckit_pkg::cmd_t  cmd;
  ckit_pkg::sts_t  sts;
  logic [CW-1:0]   entry_count;

  ckit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ckit_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cmd         (cmd),
    .sts         (sts),
    .entry_count (entry_count),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // Checks
  `CKIT_ASSERT(a_count_range, clk, rst_n, entry_count <= CW'(CAPACITY), "entry count above capacity")
  `CKIT_ASSERT(a_no_load_idle, clk, rst_n, !(in_tready && cmd.out_load), "result load while idle")
  `CKIT_ASSERT(a_ins_ok, clk, rst_n, !cmd.ins_wr || (sts.out_free && !sts.full), "insert into full table")
  `CKIT_ASSERT_NEXT(a_count_step, clk, rst_n, cmd.cnt_dec, entry_count == $past(entry_count) - CW'(1), "count did not drop")

endmodule
